// ===== hdl/set_assoc_cache_lru_sim_defines.svh =====
// ----------------------------------------------------------------------------
// Cache model assertion macros
// Shared property templates for the cache model checks.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_SIM_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define SCL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define SCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/scl_pkg.sv =====
// ----------------------------------------------------------------------------
// Cache model package
// Field widths, access codes and register indexes of the cache model.
// ----------------------------------------------------------------------------
package scl_pkg;

    localparam int ADDR_W     = 64;
    localparam int OP_W       = 2;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SET_BITS_W = 3;
    localparam int BLK_BITS_W = 6;
    localparam int WAYS_W     = 4;

    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

endpackage

// ===== hdl/scl_in_if.sv =====
// ----------------------------------------------------------------------------
// Cache model access channel
// Valid/ready channel carrying one access per beat.
// ----------------------------------------------------------------------------
interface scl_in_if import scl_pkg::*;;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;

    modport source (output valid, op, address, input ready);
    modport sink   (input valid, op, address, output ready);

endinterface

// ===== hdl/scl_out_if.sv =====
// ----------------------------------------------------------------------------
// Cache model result channel
// Valid/ready channel carrying one access outcome per beat.
// ----------------------------------------------------------------------------
interface scl_out_if import scl_pkg::*;;

    logic               valid;
    logic               ready;
    logic               hit;
    logic               miss;
    logic               evict;
    logic               last;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] evict_total;

    modport source (output valid, hit, miss, evict, last, hit_total, miss_total,
                    evict_total, input ready);
    modport sink   (input valid, hit, miss, evict, last, hit_total, miss_total,
                    evict_total, output ready);

endinterface

// ===== hdl/scl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/set_assoc_cache_lru_sim.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache model with true LRU
// Tag-only cache simulator: classifies each access as hit, miss or eviction.
// ----------------------------------------------------------------------------
// Usage:
//   i_acc carries one access per beat (op, address). o_res carries one
//   outcome per beat with hit/miss/evict flags, a last flag and saturating
//   running totals. A modify access gives two result beats, the second one
//   a hit; every other op gives one beat with last set.
//   Geometry comes from the write port (i_cfg_we, i_cfg_idx, i_cfg_data):
//   set bits, block bits and ways in use. Write it only while idle.
//   One set row (all ways) lives in a RAM row. An access runs from accept
//   to result through address split, row read, way scan (one way per
//   cycle through a single tag comparator), row write-back and result
//   load. A modify repeats the read/scan/write pass. The way scan
//   sets the rate; i_acc is not ready until the result is loaded.
//   After reset a clearing pass writes each of the 2**MAX_SET_BITS rows
//   once before the first access is taken; configuration writes are
//   taken during that pass.
//   A result waits in the output register while the receiver stalls; the
//   next access is still accepted and runs up to its result load.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim import scl_pkg::*; #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    scl_in_if.sink                i_acc,
    scl_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "set_assoc_cache_lru_sim_defines.svh"

    localparam int SETS    = 1 << MAX_SET_BITS;
    localparam int SET_W   = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
    localparam int WAY_W   = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
    localparam int REC_W   = WAY_W;
    localparam int WC_W    = $clog2(MAX_WAYS + 1) + 1;
    localparam int ENTRY_W = 1 + REC_W + ADDR_W;
    localparam int ROW_W   = MAX_WAYS * ENTRY_W;
    localparam int SB_W    = 4;
    localparam int SH_W    = 7;
    localparam int LIM_W   = REC_W + 1;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_CALC   = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [SET_BITS_W-1:0] r_set_bits;
    logic [BLK_BITS_W-1:0] r_block_bits;
    logic [WAYS_W-1:0]     r_ways_used;

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_tag;
    logic [SET_W-1:0]  r_set;
    logic [WC_W-1:0]   r_ways;
    logic              r_second;
    logic [SET_W-1:0]  r_clr_idx;

    logic [WAY_W-1:0]  r_way;
    logic              r_hit_found;
    logic [WAY_W-1:0]  r_hit_way;
    logic [REC_W-1:0]  r_hit_rec;
    logic              r_inv_found;
    logic [WAY_W-1:0]  r_inv_way;
    logic [WAY_W-1:0]  r_old_way;
    logic [REC_W-1:0]  r_old_rec;

    logic               r_res_hit;
    logic               r_res_miss;
    logic               r_res_evict;
    logic [TOTAL_W-1:0] r_hits;
    logic [TOTAL_W-1:0] r_misses;
    logic [TOTAL_W-1:0] r_evicts;

    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_miss;
    logic               r_out_evict;
    logic               r_out_last;
    logic [TOTAL_W-1:0] r_out_hits;
    logic [TOTAL_W-1:0] r_out_misses;
    logic [TOTAL_W-1:0] r_out_evicts;

    logic [ROW_W-1:0]   rd_row;
    logic [ROW_W-1:0]   n_row;
    logic               ram_we;
    logic [SET_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;

    logic               acc_beat;
    logic               emit_go;
    logic               scan_done;
    logic               is_modify;

    // Address split
    logic [SB_W-1:0]    sb_eff;
    logic [SH_W-1:0]    shamt;
    logic [ADDR_W-1:0]  addr_blk;
    logic [SET_W-1:0]   calc_set;
    logic [ADDR_W-1:0]  calc_tag;
    logic [WC_W-1:0]    calc_ways;

    // Current way of the scan
    logic [ENTRY_W-1:0] cur_entry;
    logic               cur_valid;
    logic [REC_W-1:0]   cur_rec;
    logic [ADDR_W-1:0]  cur_tag;

    // Update decision
    logic [WAY_W-1:0]   tgt_way;
    logic [LIM_W-1:0]   age_lim;
    logic               upd_miss;
    logic               upd_evict;

    assign acc_beat    = i_acc.valid && i_acc.ready;
    assign i_acc.ready = (r_state == ST_IDLE);
    assign emit_go     = (r_state == ST_EMIT) && (!r_out_valid || o_res.ready);
    assign scan_done   = (WC_W'(r_way) + WC_W'(1)) == r_ways;
    assign is_modify   = (r_op == OP_MODIFY);

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways_used  <= WAYS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLK_BITS_W-1:0];
                CFG_WAYS_USED:  r_ways_used  <= i_cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- address split
    always_comb begin
        if (int'(r_set_bits) > MAX_SET_BITS) begin
            sb_eff = SB_W'(MAX_SET_BITS);
        end else begin
            sb_eff = SB_W'(r_set_bits);
        end
        shamt    = SH_W'(sb_eff) + SH_W'(r_block_bits);
        addr_blk = r_addr >> r_block_bits;
        for (int i = 0; i < SET_W; i++) begin
            calc_set[i] = addr_blk[i] && (i < int'(sb_eff));
        end
        if (shamt >= SH_W'(ADDR_W)) begin
            calc_tag = '0;
        end else begin
            calc_tag = r_addr >> shamt;
        end
        if (r_ways_used == '0) begin
            calc_ways = WC_W'(1);
        end else if (int'(r_ways_used) > MAX_WAYS) begin
            calc_ways = WC_W'(MAX_WAYS);
        end else begin
            calc_ways = WC_W'(r_ways_used);
        end
    end

    // ------------------------------------------------------------ way scan
    assign cur_entry = rd_row[r_way * ENTRY_W +: ENTRY_W];
    assign cur_valid = cur_entry[ENTRY_W-1];
    assign cur_rec   = cur_entry[ADDR_W +: REC_W];
    assign cur_tag   = cur_entry[ADDR_W-1:0];

    // ---------------------------------------------------------- row update
    always_comb begin
        logic [ENTRY_W-1:0] ent;
        logic [REC_W-1:0]   rec;
        upd_miss  = !r_hit_found;
        upd_evict = !r_hit_found && !r_inv_found;
        if (r_hit_found) begin
            tgt_way = r_hit_way;
            age_lim = LIM_W'(r_hit_rec);
        end else if (r_inv_found) begin
            tgt_way = r_inv_way;
            age_lim = '1;
        end else begin
            tgt_way = r_old_way;
            age_lim = LIM_W'(r_old_rec);
        end
        n_row = rd_row;
        for (int i = 0; i < MAX_WAYS; i++) begin
            ent = rd_row[i*ENTRY_W +: ENTRY_W];
            rec = ent[ADDR_W +: REC_W];
            if (WAY_W'(i) == tgt_way) begin
                ent[ADDR_W +: REC_W] = '0;
                if (upd_miss) begin
                    ent[ENTRY_W-1]  = 1'b1;
                    ent[ADDR_W-1:0] = r_tag;
                end
            end else if ((WC_W'(i) < r_ways) && ent[ENTRY_W-1] &&
                         (LIM_W'(rec) < age_lim) && (rec != REC_W'(MAX_WAYS - 1))) begin
                ent[ADDR_W +: REC_W] = rec + REC_W'(1);
            end
            n_row[i*ENTRY_W +: ENTRY_W] = ent;
        end
    end

    assign ram_we    = (r_state == ST_CLEAR) || (r_state == ST_UPDATE);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_set;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : n_row;

    scl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_addr (r_set),
        .o_rd_data (rd_row)
    );

    // ------------------------------------------------------------ sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (r_clr_idx == SET_W'(SETS - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (acc_beat) n_state = ST_CALC;
            ST_CALC:   n_state = ST_READ;
            ST_READ:   n_state = ST_SCAN;
            ST_SCAN:   if (scan_done) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_go) begin
                    n_state = (is_modify && !r_second) ? ST_READ : ST_IDLE;
                end
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_second  <= 1'b0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_evicts  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
            if (acc_beat) begin
                r_second <= 1'b0;
            end else if (emit_go && is_modify) begin
                r_second <= 1'b1;
            end
            if (r_state == ST_UPDATE) begin
                if (!upd_miss && r_hits != '1) begin
                    r_hits <= r_hits + TOTAL_W'(1);
                end
                if (upd_miss && r_misses != '1) begin
                    r_misses <= r_misses + TOTAL_W'(1);
                end
                if (upd_evict && r_evicts != '1) begin
                    r_evicts <= r_evicts + TOTAL_W'(1);
                end
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (acc_beat) begin
            r_op   <= i_acc.op;
            r_addr <= i_acc.address;
        end
        if (r_state == ST_CALC) begin
            r_tag  <= calc_tag;
            r_set  <= calc_set;
            r_ways <= calc_ways;
        end
        if (r_state == ST_READ) begin
            r_way       <= '0;
            r_hit_found <= 1'b0;
            r_inv_found <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            r_way <= r_way + WAY_W'(1);
            if (cur_valid && cur_tag == r_tag && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_way   <= r_way;
                r_hit_rec   <= cur_rec;
            end
            if (!cur_valid && !r_inv_found) begin
                r_inv_found <= 1'b1;
                r_inv_way   <= r_way;
            end
            // Oldest way, lowest number wins a tie
            if (r_way == '0 || cur_rec > r_old_rec) begin
                r_old_way <= r_way;
                r_old_rec <= cur_rec;
            end
        end
        if (r_state == ST_UPDATE) begin
            r_res_hit   <= !upd_miss;
            r_res_miss  <= upd_miss;
            r_res_evict <= upd_evict;
        end
    end

    // --------------------------------------------------------- result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_hit    <= r_res_hit;
            r_out_miss   <= r_res_miss;
            r_out_evict  <= r_res_evict;
            r_out_last   <= !(is_modify && !r_second);
            r_out_hits   <= r_hits;
            r_out_misses <= r_misses;
            r_out_evicts <= r_evicts;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.hit         = r_out_hit;
    assign o_res.miss        = r_out_miss;
    assign o_res.evict       = r_out_evict;
    assign o_res.last        = r_out_last;
    assign o_res.hit_total   = r_out_hits;
    assign o_res.miss_total  = r_out_misses;
    assign o_res.evict_total = r_out_evicts;

    // ----------------------------------------------------------- assertions
    `SCL_ASSERT_NOW(a_one_outcome, i_clk, i_rst_n, r_out_valid,
        (r_out_hit != r_out_miss) && (!r_out_evict || r_out_miss),
        "result beat must be exactly one of hit or miss, evict only on miss")
    `SCL_ASSERT_NOW(a_second_hits, i_clk, i_rst_n, emit_go && r_second,
        r_res_hit, "second access of a modify must hit")
    `SCL_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n, r_state == ST_SCAN,
        WC_W'(r_way) < r_ways, "way scan ran past the ways in use")
    `SCL_ASSERT_NEXT(a_hits_monotone, i_clk, i_rst_n, r_state != ST_CLEAR,
        r_hits >= $past(r_hits), "hit total went backwards")

endmodule

// ===== tb/set_assoc_cache_lru_sim_test.sv =====
// ----------------------------------------------------------------------------
// Set-associative LRU cache model testbench
// Drives access beats under several cache geometries and random idling,
// predicts every outcome beat with an internal LRU cache model and checks
// the result channel beat by beat, flags and running totals alike.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_test import scl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_BITS_CAP  = 6;
    localparam int WAYS_CAP      = 8;
    localparam int LINE_SLOTS    = (1 << SET_BITS_CAP) * WAYS_CAP;
    localparam int AGE_CAP       = WAYS_CAP - 1;
    localparam int SHOWN_ERRORS  = 10;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE = 2'd1;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic               hit;
        logic               miss;
        logic               evict;
        logic               last;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] miss_total;
        logic [TOTAL_W-1:0] evict_total;
    } t_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    scl_in_if  acc ();
    scl_out_if res ();

    set_assoc_cache_lru_sim dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // cache model state
    logic                  line_valid_m [LINE_SLOTS];
    logic [ADDR_W-1:0]     line_tag_m   [LINE_SLOTS];
    logic [2:0]            line_age_m   [LINE_SLOTS];
    logic [TOTAL_W-1:0]    hits_m;
    logic [TOTAL_W-1:0]    misses_m;
    logic [TOTAL_W-1:0]    evicts_m;
    logic [SET_BITS_W-1:0] cfg_set_bits;
    logic [BLK_BITS_W-1:0] cfg_block_bits;
    logic [WAYS_W-1:0]     cfg_ways;

    t_outcome          expected_outcomes [$];
    int                mismatches     = 0;
    int                send_idle_pct  = 0;
    int                take_idle_pct  = 0;
    int                take_hold_left = 0;
    logic [ADDR_W-1:0] tag_base       = '0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void clear_cache_model();
        for (int i = 0; i < LINE_SLOTS; i++) begin
            line_valid_m[i] = 1'b0;
            line_tag_m[i]   = '0;
            line_age_m[i]   = '0;
        end
        hits_m         = '0;
        misses_m       = '0;
        evicts_m       = '0;
        cfg_set_bits   = '0;
        cfg_block_bits = '0;
        cfg_ways       = WAYS_W'(1);
    endfunction

    function automatic void write_cfg_model(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SET_BITS:   cfg_set_bits   = data[SET_BITS_W-1:0];
            CFG_BLOCK_BITS: cfg_block_bits = data[BLK_BITS_W-1:0];
            CFG_WAYS_USED:  cfg_ways       = data[WAYS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int eff_set_bits();
        return (cfg_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : int'(cfg_set_bits);
    endfunction

    function automatic int eff_ways();
        if (cfg_ways == 0)
            return 1;
        return (cfg_ways > WAYS_CAP) ? WAYS_CAP : int'(cfg_ways);
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Make way w the newest; valid ways younger than limit age by one.
    function automatic void promote_way(input int base, input int ways, input int w,
                                        input int limit);
        for (int i = 0; i < ways; i++) begin
            if (i != w && line_valid_m[base + i] && line_age_m[base + i] < limit &&
                line_age_m[base + i] < AGE_CAP)
                line_age_m[base + i] = line_age_m[base + i] + 1'b1;
        end
        line_age_m[base + w] = '0;
    endfunction

    function automatic void predict_access(input logic [ADDR_W-1:0] addr,
                                           input logic is_last);
        int                sb;
        int                bb;
        int                ways;
        int                base;
        int                way;
        logic              found;
        logic [ADDR_W-1:0] set_idx;
        logic [ADDR_W-1:0] tag;
        t_outcome          o;
        sb      = eff_set_bits();
        bb      = int'(cfg_block_bits);
        ways    = eff_ways();
        set_idx = (addr >> bb) & ((64'd1 << sb) - 1);
        tag     = (sb + bb >= ADDR_W) ? '0 : (addr >> (sb + bb));
        base    = int'(set_idx) * WAYS_CAP;
        found   = 1'b0;
        way     = 0;
        o       = '0;
        for (int i = 0; i < ways && !found; i++) begin
            if (line_valid_m[base + i] && line_tag_m[base + i] == tag) begin
                found = 1'b1;
                way   = i;
            end
        end
        if (found) begin
            o.hit = 1'b1;
            promote_way(base, ways, way, int'(line_age_m[base + way]));
            hits_m = sat_inc(hits_m);
        end else begin
            o.miss = 1'b1;
            for (int i = 0; i < ways && !found; i++) begin
                if (!line_valid_m[base + i]) begin
                    found = 1'b1;
                    way   = i;
                end
            end
            if (found) begin
                promote_way(base, ways, way, 255);
            end else begin
                // oldest way wins, lowest index on a tie
                way = 0;
                for (int i = 1; i < ways; i++)
                    if (line_age_m[base + i] > line_age_m[base + way])
                        way = i;
                o.evict = 1'b1;
                promote_way(base, ways, way, int'(line_age_m[base + way]));
                evicts_m = sat_inc(evicts_m);
            end
            line_valid_m[base + way] = 1'b1;
            line_tag_m[base + way]   = tag;
            misses_m = sat_inc(misses_m);
        end
        o.last        = is_last;
        o.hit_total   = hits_m;
        o.miss_total  = misses_m;
        o.evict_total = evicts_m;
        expected_outcomes.push_back(o);
    endfunction

    function automatic void predict_item(input logic [OP_W-1:0] op,
                                         input logic [ADDR_W-1:0] addr);
        if (op == OP_MODIFY) begin
            predict_access(addr, 1'b0);
            predict_access(addr, 1'b1);
        end else begin
            predict_access(addr, 1'b1);
        end
    endfunction

    // Address from a small tag pool over a few sets, now and then fully random.
    function automatic logic [ADDR_W-1:0] pick_address();
        int                sb;
        int                bb;
        logic [ADDR_W-1:0] tagv;
        logic [ADDR_W-1:0] setv;
        logic [ADDR_W-1:0] offv;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        sb   = eff_set_bits();
        bb   = int'(cfg_block_bits);
        tagv = tag_base + ADDR_W'($urandom_range(0, eff_ways() + 2));
        setv = ADDR_W'($urandom_range(0, 3));
        offv = {$urandom, $urandom};
        return ((sb + bb >= ADDR_W) ? 64'd0 : (tagv << (sb + bb))) |
               ((setv & ((64'd1 << sb) - 1)) << bb) |
               (offv & ((64'd1 << bb) - 1));
    endfunction

    task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] want,
                                   input logic [TOTAL_W-1:0] got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (got !== want)
            report_mismatch(what, want, got);
    endtask

    task automatic check_outcome();
        t_outcome want;
        if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result beat, pending", 0, 1);
            return;
        end
        want = expected_outcomes.pop_front();
        check_field("hit", TOTAL_W'(want.hit), TOTAL_W'(res.hit));
        check_field("miss", TOTAL_W'(want.miss), TOTAL_W'(res.miss));
        check_field("evict", TOTAL_W'(want.evict), TOTAL_W'(res.evict));
        check_field("last", TOTAL_W'(want.last), TOTAL_W'(res.last));
        check_field("hit_total", want.hit_total, res.hit_total);
        check_field("miss_total", want.miss_total, res.miss_total);
        check_field("evict_total", want.evict_total, res.evict_total);
    endtask

    // result side: check each beat, then pick ready for the next cycle
    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid === 1'b1 && res.ready === 1'b1)
                check_outcome();
            if (take_hold_left > 0) begin
                take_hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(0, 99) >= take_idle_pct);
            end
        end
    end

    task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        acc.valid   <= 1'b1;
        acc.op      <= op;
        acc.address <= addr;
        @(posedge i_clk);
        while (acc.ready !== 1'b1)
            @(posedge i_clk);
        predict_item(op, addr);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            acc.valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // Hold the sender until every pending beat is back, then let the block settle.
    task automatic wait_drained();
        acc.valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        write_cfg_model(idx, data);
    endtask

    task automatic apply_geometry(input logic [CFG_DATA_W-1:0] sb,
                                  input logic [CFG_DATA_W-1:0] bb,
                                  input logic [CFG_DATA_W-1:0] wy);
        cfg_write(CFG_SET_BITS, sb);
        cfg_write(CFG_BLOCK_BITS, bb);
        cfg_write(CFG_WAYS_USED, wy);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int take_pct);
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
    endtask

    // Direct-mapped default geometry, every op code, address extremes.
    task automatic test_default_geometry();
        apply_geometry(0, 0, 1);
        send_access(OP_LOAD, 64'd0);
        send_access(OP_STORE, 64'd0);
        send_access(OP_MODIFY, '1);
        send_access(OP_SPARE, 64'd0);
        send_access(OP_LOAD, 64'd1);
    endtask

    // Saturated set bits, wide offsets and out-of-range way counts.
    task automatic test_extreme_geometry();
        wait_drained();
        apply_geometry(7, 63, 15);
        send_access(OP_LOAD, 64'd0);
        send_access(OP_LOAD, '1);
        send_access(OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
        send_access(OP_MODIFY, 64'h8000_0000_0000_0000);
        wait_drained();
        apply_geometry(0, 32, 0);
        send_access(OP_LOAD, 64'h0000_0000_FFFF_FFFF);
        send_access(OP_LOAD, 64'h0000_0001_0000_0000);
        send_access(OP_STORE, 64'h0000_0001_FFFF_FFFF);
        wait_drained();
        apply_geometry(6, 58, 8);
        send_access(OP_LOAD, 64'hFC00_0000_0000_0000);
    endtask

    // Fill a set, refresh, evict, then shrink and regrow the way count.
    task automatic test_lru_order();
        wait_drained();
        apply_geometry(2, 4, 4);
        for (int t = 0; t < 4; t++)
            send_access(OP_LOAD, 64'(t) << 6);
        send_access(OP_LOAD, 64'd0);
        send_access(OP_STORE, 64'd4 << 6);
        send_access(OP_LOAD, 64'd1 << 6);
        send_access(OP_MODIFY, 64'd2 << 6);
        wait_drained();
        apply_geometry(2, 4, 2);
        send_access(OP_LOAD, 64'd3 << 6);
        send_access(OP_LOAD, 64'd5 << 6);
        wait_drained();
        apply_geometry(2, 4, 8);
        send_access(OP_LOAD, 64'd0);
    endtask

    task automatic test_random_accesses();
        logic [CFG_DATA_W-1:0] sbs [8] = '{6, 2, 7, 1, 3, 6, 4, 0};
        logic [CFG_DATA_W-1:0] bbs [8] = '{6, 4, 0, 63, 32, 58, 5, 2};
        logic [CFG_DATA_W-1:0] wys [8] = '{8, 4, 15, 2, 0, 8, 3, 8};
        for (int g = 0; g < 8; g++) begin
            if (g == 3)
                set_idling(59, 22);
            else if (g == 6)
                set_idling(0, 0);
            wait_drained();
            apply_geometry(sbs[g], bbs[g], wys[g]);
            tag_base = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
            for (int n = 0; n < 100; n++)
                send_access(OP_W'($urandom_range(0, 3)), pick_address());
        end
    endtask

    // Stall the result side for a long stretch while beats keep coming.
    task automatic test_output_backpressure();
        wait_drained();
        set_idling(0, 0);
        apply_geometry(2, 4, 4);
        tag_base       = '0;
        take_hold_left = 400;
        for (int n = 0; n < 24; n++)
            send_access(OP_W'($urandom_range(0, 3)), pick_address());
        wait_drained();
    endtask

    initial begin
        clear_cache_model();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        acc.valid   <= 1'b0;
        acc.op      <= '0;
        acc.address <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(22, 59);
        test_default_geometry();
        test_extreme_geometry();
        test_lru_order();
        test_random_accesses();
        test_output_backpressure();
        wait_drained();
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/scl_pkg.sv
hdl/scl_in_if.sv
hdl/scl_out_if.sv
hdl/scl_ram.sv
hdl/set_assoc_cache_lru_sim.sv
tb/set_assoc_cache_lru_sim_test.sv
